// ===== design/sib_pkg.sv =====
// Shared types and constants for the sorted insertion buffer.
package sib_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int LIMIT_W = 6;
    localparam int PADDR_W = 3;

    // Register word indexes on the configuration port
    localparam logic [PADDR_W-3:0] REG_ENTRY_LIMIT = 1'd0;

    localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_REJECT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic pos_dec;
        logic rd_sel_k;
        logic wr_en;
        logic wr_sel_item;
        logic fill_inc;
        logic k_clr;
        logic k_inc;
        logic out_load;
        logic out_reject;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic fill_zero;
        logic pos_one;
        logic greater;
        logic k_last;
        logic out_free;
    } status_t;

endpackage

// ===== design/sib_ctrl.sv =====
// Controller: sequences insert, shift, place and read-out of the sorted list, and the reject result.
module sib_ctrl
    import sib_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.full)
                    begin
                        state_next = ST_REJECT;
                    end
                    else if (status.fill_zero)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_CMP;
            end
            ST_SHIFT_CMP:
            begin
                // move the larger neighbor up one slot; equal entries stay ahead
                if (status.greater)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.pos_dec = 1'b1;
                    state_next  = status.pos_one ? ST_PLACE : ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel_item = 1'b1;
                cmd.fill_inc    = 1'b1;
                cmd.k_clr       = 1'b1;
                state_next      = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_sel_k = 1'b1;
                state_next   = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.rd_sel_k = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.k_inc    = 1'b1;
                    state_next   = status.k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_REJECT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_reject = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sib_datapath.sv =====
// Datapath: entry memory, insert pointers, fill count and result register.
module sib_datapath
    import sib_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [LIMIT_W-1:0]  entry_limit,
    input  logic [DATA_W-1:0]   new_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   entry_value,
    output logic [POS_W-1:0]    entry_position,
    output logic                last_entry,
    output logic                rejected
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] item_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     k_reg;
    logic [CW-1:0]     fill_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;
    logic              out_rej_reg;

    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic [LW-1:0]     limit_ext;
    logic [LW-1:0]     eff_limit;
    logic              k_last;

    assign rd_addr = cmd.rd_sel_k ? k_reg : pos_reg - AW'(1);
    assign wr_data = cmd.wr_sel_item ? item_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= new_value;
            pos_reg  <= fill_reg[AW-1:0];
        end
        else if (cmd.pos_dec)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.fill_inc)
        begin
            fill_reg <= fill_reg + CW'(1);
        end
    end

    // Saturate the limit at the physical capacity
    assign limit_ext = LW'(entry_limit);
    assign eff_limit = (limit_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : limit_ext;
    assign k_last    = (CW'(k_reg) == fill_reg - CW'(1));

    always_comb
    begin
        status.full      = (LW'(fill_reg) >= eff_limit);
        status.fill_zero = (fill_reg == '0);
        status.pos_one   = (pos_reg == AW'(1));
        status.greater   = (rd_data_reg > item_reg);
        status.k_last    = k_last;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // Result register: hold while stalled, drop valid once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_reject)
            begin
                out_value_reg <= '0;
                out_pos_reg   <= '0;
                out_last_reg  <= 1'b1;
                out_rej_reg   <= 1'b1;
            end
            else
            begin
                out_value_reg <= rd_data_reg;
                out_pos_reg   <= POS_W'(k_reg);
                out_last_reg  <= k_last;
                out_rej_reg   <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_value    = out_value_reg;
    assign entry_position = out_pos_reg;
    assign last_entry     = out_last_reg;
    assign rejected       = out_rej_reg;

endmodule

// ===== design/sorted_insertion_buffer_unit.sv =====
// Sorted insertion buffer: an accepted insert scans down from the fill point, reading each
// entry and moving it up one slot while it is larger than the new value; the scan stops on a
// smaller or equal entry or at the bottom slot, and then the value is placed. Every entry is
// then emitted in order as a result, each by a registered read and a result register load;
// a load waits while the result register is stalled. A refused insert gives a rejected result.
// Reset clears the fill count and result valid and sets entry_limit to 32;
// entry storage is not cleared and an entry is never used before it is written.
module sorted_insertion_buffer_unit
    import sib_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DATA_W-1:0]   new_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   entry_value,
    output logic [POS_W-1:0]    entry_position,
    output logic                last_entry,
    output logic                rejected
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               limit_sel;
    cmd_t               cmd;
    status_t            status;

    assign pready    = 1'b1;
    assign limit_sel = (paddr[PADDR_W-1:2] == REG_ENTRY_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ENTRY_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && limit_sel)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = limit_sel ? {{(32 - LIMIT_W){1'b0}}, limit_reg} : 32'd0;

    sib_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sib_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .entry_limit    (limit_reg),
        .new_value      (new_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_value    (entry_value),
        .entry_position (entry_position),
        .last_entry     (last_entry),
        .rejected       (rejected)
    );

endmodule
